/* rtl/mfts_pkg.sv */
// Package for the feedback task scheduler: sizes, command/status codes,
// task modes and the task table word layout. No dependencies.
`default_nettype none
package mfts_pkg;
    localparam int MAX_TASKS = 16;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = TASK_W + 1;
    localparam int QNUM      = 5;          // four ready queues and the sleep queue
    localparam int Q_W       = 3;
    localparam int FIFO_AW   = Q_W + TASK_W;
    localparam logic [Q_W-1:0] SLEEP_Q = 3'd4;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_TICK  = 3'd1;
    localparam logic [2:0] CMD_SLEEP = 3'd2;
    localparam logic [2:0] CMD_WAIT  = 3'd3;
    localparam logic [2:0] CMD_WAKE  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_REJ  = 2'd2;

    localparam logic [1:0] CFG_TOP = 2'd0;
    localparam logic [1:0] CFG_MID = 2'd1;
    localparam logic [1:0] CFG_LOW = 2'd2;

    typedef enum logic [1:0] {
        MODE_READY = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_SLEEP = 2'd2,
        MODE_WAIT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [31:0] sleep_span;
        logic [31:0] sleep_start;
        logic [31:0] dispatches;
        logic [7:0]  slice;
        logic [1:0]  feedback;
        logic [1:0]  base;
    } task_entry_t;

    localparam int ENTRY_W = $bits(task_entry_t);
endpackage
`default_nettype wire

/* rtl/mfts_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mfts_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/multilevel_feedback_task_scheduler_top.sv */
// Top level of the four-level feedback task scheduler: command sequencer,
// queue pointers, running-task shadow. Uses mfts_pkg and mfts_ram.
//
//  port group    dir  beat contents
//  s_*           in   command: cmd, task_id, task_level, now_time, sleep_ticks
//  m_*           out  result: status, running_valid/task/base/level/count
//  cfg_*         in   slice register writes (index 0 top, 1 mid, 2 low)
//
// Add, wake and rejected commands do no scheduling pass. A tick, sleep or
// wait steps the running task's slice, re-checks the head sleeper and, when
// levels 3..1 are empty, walks each task at level 0 back to its base level
// before the pick. Reset clears the control state at once; no clearing
// pass. A stalled result holds the sequencer in its final state; a new
// command is taken after it is loaded.
`default_nettype none
module multilevel_feedback_task_scheduler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] cmd, [6:3] task_id, [8:7] task_level, [40:9] now_time,
    // [72:41] sleep_ticks, [79:73] zero
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [2] running_valid, [6:3] running_task, [8:7] running_base,
    // [10:9] running_level, [42:11] running_count, [47:43] zero
    output logic      [47:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int TW = mfts_pkg::TASK_W;
    localparam int CW = mfts_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_WAKE, S_SCHED, S_SLP_RD, S_SLP_POP, S_SLP_CHK,
        S_PICK, S_PICK_POP, S_PICK_LOAD, S_RF_RD, S_RF_POP, S_RF_WR, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Slice registers
    logic [7:0] slice_top_reg, slice_mid_reg, slice_low_reg;
    logic [7:0] grant_tab [4];
    assign grant_tab[0] = 8'd0;
    assign grant_tab[1] = slice_low_reg;
    assign grant_tab[2] = slice_mid_reg;
    assign grant_tab[3] = slice_top_reg;

    // Latched command
    logic [2:0]    cmd_reg, cmd_next;
    logic [TW-1:0] id_reg, id_next;
    logic [1:0]    lvl_in_reg, lvl_in_next;
    logic [31:0]   now_reg, now_next;
    logic [31:0]   span_reg, span_next;

    // Per-task flags and modes
    logic                 used_reg [mfts_pkg::MAX_TASKS];
    logic                 used_next [mfts_pkg::MAX_TASKS];
    mfts_pkg::mode_t      mode_reg [mfts_pkg::MAX_TASKS];
    mfts_pkg::mode_t      mode_next [mfts_pkg::MAX_TASKS];

    // Queue pointers
    logic [TW-1:0] head_reg [mfts_pkg::QNUM];
    logic [TW-1:0] head_next [mfts_pkg::QNUM];
    logic [CW-1:0] count_reg [mfts_pkg::QNUM];
    logic [CW-1:0] count_next [mfts_pkg::QNUM];

    // Running task
    logic                  cur_valid_reg, cur_valid_next;
    logic [TW-1:0]         cur_id_reg, cur_id_next;
    mfts_pkg::task_entry_t shadow_reg, shadow_next;

    // Sequencer scratch
    logic [TW-1:0] sel_reg, sel_next;
    logic [1:0]    lvl_reg, lvl_next;
    logic [CW-1:0] left_reg, left_next;
    logic          refill_reg, refill_next;
    logic [1:0]    status_reg, status_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;

    // Memory ports
    logic                          tbl_we;
    logic [TW-1:0]                 tbl_waddr, tbl_raddr;
    mfts_pkg::task_entry_t         tbl_wdata, tbl_rdata;
    logic                          fifo_we;
    logic [mfts_pkg::FIFO_AW-1:0]  fifo_waddr, fifo_raddr;
    logic [TW-1:0]                 fifo_wdata, fifo_rdata;

    mfts_ram #(.DATA_W(mfts_pkg::ENTRY_W), .ADDR_W(TW)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    mfts_ram #(.DATA_W(TW), .ADDR_W(mfts_pkg::FIFO_AW)) u_queues (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sequencer next state
    always_comb
    begin
        mfts_pkg::task_entry_t e;
        logic [1:0] fb;
        logic [mfts_pkg::Q_W-1:0] q;
        logic [31:0] waited;
        e      = shadow_reg;
        fb     = 2'd0;
        q      = '0;
        waited = 32'd0;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        lvl_in_next    = lvl_in_reg;
        now_next       = now_reg;
        span_next      = span_reg;
        used_next      = used_reg;
        mode_next      = mode_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        shadow_next    = shadow_reg;
        sel_next       = sel_reg;
        lvl_next       = lvl_reg;
        left_next      = left_reg;
        refill_next    = refill_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        tbl_we     = 1'b0;
        tbl_waddr  = cur_id_reg;
        tbl_wdata  = shadow_reg;
        tbl_raddr  = id_reg;
        fifo_we    = 1'b0;
        fifo_waddr = '0;
        fifo_wdata = '0;
        fifo_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tdata[2:0];
                    id_next     = s_tdata[6:3];
                    lvl_in_next = s_tdata[8:7];
                    now_next    = s_tdata[40:9];
                    span_next   = s_tdata[72:41];
                    refill_next = 1'b0;
                    status_next = mfts_pkg::ST_REJ;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    mfts_pkg::CMD_ADD:
                    begin
                        if (!used_reg[id_reg])
                        begin
                            e.base        = lvl_in_reg;
                            e.feedback    = lvl_in_reg;
                            e.slice       = grant_tab[lvl_in_reg];
                            e.dispatches  = 32'd0;
                            e.sleep_start = 32'd0;
                            e.sleep_span  = 32'd0;
                            tbl_we        = 1'b1;
                            tbl_waddr     = id_reg;
                            tbl_wdata     = e;
                            used_next[id_reg] = 1'b1;
                            mode_next[id_reg] = mfts_pkg::MODE_READY;
                            q = {1'b0, lvl_in_reg};
                            fifo_we    = 1'b1;
                            fifo_wdata = id_reg;
                            fifo_waddr = {q, head_reg[q] + count_reg[q][TW-1:0]};
                            count_next[q] = count_reg[q] + 1'b1;
                            status_next = mfts_pkg::ST_OK;
                        end
                    end
                    mfts_pkg::CMD_TICK:
                    begin
                        state_next = S_SCHED;
                    end
                    mfts_pkg::CMD_SLEEP:
                    begin
                        if (cur_valid_reg)
                        begin
                            mode_next[cur_id_reg]  = mfts_pkg::MODE_SLEEP;
                            shadow_next.sleep_start = now_reg;
                            shadow_next.sleep_span  = span_reg;
                            q = mfts_pkg::SLEEP_Q;
                            fifo_we    = 1'b1;
                            fifo_wdata = cur_id_reg;
                            fifo_waddr = {q, head_reg[q] + count_reg[q][TW-1:0]};
                            count_next[q] = count_reg[q] + 1'b1;
                            state_next = S_SCHED;
                        end
                    end
                    mfts_pkg::CMD_WAIT:
                    begin
                        if (cur_valid_reg)
                        begin
                            mode_next[cur_id_reg] = mfts_pkg::MODE_WAIT;
                            state_next = S_SCHED;
                        end
                    end
                    mfts_pkg::CMD_WAKE:
                    begin
                        if (used_reg[id_reg] && mode_reg[id_reg] == mfts_pkg::MODE_WAIT)
                        begin
                            tbl_raddr  = id_reg;
                            state_next = S_WAKE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Requeue a woken task at its feedback level
            S_WAKE:
            begin
                mode_next[id_reg] = mfts_pkg::MODE_READY;
                q = {1'b0, tbl_rdata.feedback};
                fifo_we    = 1'b1;
                fifo_wdata = id_reg;
                fifo_waddr = {q, head_reg[q] + count_reg[q][TW-1:0]};
                count_next[q] = count_reg[q] + 1'b1;
                status_next = mfts_pkg::ST_OK;
                state_next  = S_DONE;
            end

            // Slice step for the running task, write back its entry, requeue it if still running
            S_SCHED:
            begin
                if (cur_valid_reg)
                begin
                    fb = shadow_reg.feedback;
                    if (shadow_reg.slice <= 8'd1)
                    begin
                        if (fb != 2'd0)
                        begin
                            fb = fb - 2'd1;
                        end
                        e.feedback = fb;
                        e.slice    = grant_tab[fb];
                    end
                    else
                    begin
                        e.slice = shadow_reg.slice - 8'd1;
                    end
                    tbl_we    = 1'b1;
                    tbl_waddr = cur_id_reg;
                    tbl_wdata = e;
                    if (mode_reg[cur_id_reg] == mfts_pkg::MODE_RUN)
                    begin
                        mode_next[cur_id_reg] = mfts_pkg::MODE_READY;
                        q = {1'b0, fb};
                        fifo_we    = 1'b1;
                        fifo_wdata = cur_id_reg;
                        fifo_waddr = {q, head_reg[q] + count_reg[q][TW-1:0]};
                        count_next[q] = count_reg[q] + 1'b1;
                    end
                    cur_valid_next = 1'b0;
                end
                state_next = S_SLP_RD;
            end

            S_SLP_RD:
            begin
                if (count_reg[mfts_pkg::SLEEP_Q] != '0)
                begin
                    fifo_raddr = {mfts_pkg::SLEEP_Q, head_reg[mfts_pkg::SLEEP_Q]};
                    state_next = S_SLP_POP;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_SLP_POP:
            begin
                sel_next  = fifo_rdata;
                tbl_raddr = fifo_rdata;
                head_next[mfts_pkg::SLEEP_Q]  = head_reg[mfts_pkg::SLEEP_Q] + 1'b1;
                count_next[mfts_pkg::SLEEP_Q] = count_reg[mfts_pkg::SLEEP_Q] - 1'b1;
                state_next = S_SLP_CHK;
            end

            // Sleeper done: back to its ready queue, else to the sleep tail
            S_SLP_CHK:
            begin
                e      = tbl_rdata;
                waited = now_reg - e.sleep_start;
                fifo_we    = 1'b1;
                fifo_wdata = sel_reg;
                if (waited >= e.sleep_span)
                begin
                    mode_next[sel_reg] = mfts_pkg::MODE_READY;
                    e.sleep_start = 32'd0;
                    e.sleep_span  = 32'd0;
                    tbl_we    = 1'b1;
                    tbl_waddr = sel_reg;
                    tbl_wdata = e;
                    q = {1'b0, e.feedback};
                end
                else
                begin
                    q = mfts_pkg::SLEEP_Q;
                end
                fifo_waddr = {q, head_reg[q] + count_reg[q][TW-1:0]};
                count_next[q] = count_reg[q] + 1'b1;
                state_next = S_PICK;
            end

            // Highest non-empty queue among levels 3..1; if none, refill once, then report none
            S_PICK:
            begin
                if (count_reg[3] != '0 || count_reg[2] != '0 || count_reg[1] != '0)
                begin
                    if (count_reg[3] != '0)
                    begin
                        lvl_next = 2'd3;
                    end
                    else if (count_reg[2] != '0)
                    begin
                        lvl_next = 2'd2;
                    end
                    else
                    begin
                        lvl_next = 2'd1;
                    end
                    fifo_raddr = {1'b0, lvl_next, head_reg[{1'b0, lvl_next}]};
                    state_next = S_PICK_POP;
                end
                else if (!refill_reg)
                begin
                    refill_next = 1'b1;
                    left_next   = count_reg[0];
                    state_next  = S_RF_RD;
                end
                else
                begin
                    status_next = mfts_pkg::ST_NONE;
                    state_next  = S_DONE;
                end
            end

            S_PICK_POP:
            begin
                sel_next  = fifo_rdata;
                tbl_raddr = fifo_rdata;
                head_next[{1'b0, lvl_reg}]  = head_reg[{1'b0, lvl_reg}] + 1'b1;
                count_next[{1'b0, lvl_reg}] = count_reg[{1'b0, lvl_reg}] - 1'b1;
                state_next = S_PICK_LOAD;
            end

            // Dispatch: entry goes into the shadow
            S_PICK_LOAD:
            begin
                shadow_next = tbl_rdata;
                shadow_next.dispatches = tbl_rdata.dispatches + 32'd1;
                mode_next[sel_reg] = mfts_pkg::MODE_RUN;
                cur_valid_next = 1'b1;
                cur_id_next    = sel_reg;
                status_next    = mfts_pkg::ST_OK;
                state_next     = S_DONE;
            end

            // Refill walk over the tasks queued at level 0
            S_RF_RD:
            begin
                if (left_reg == '0)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    fifo_raddr = {3'd0, head_reg[0]};
                    state_next = S_RF_POP;
                end
            end

            S_RF_POP:
            begin
                sel_next  = fifo_rdata;
                tbl_raddr = fifo_rdata;
                head_next[0]  = head_reg[0] + 1'b1;
                count_next[0] = count_reg[0] - 1'b1;
                state_next = S_RF_WR;
            end

            S_RF_WR:
            begin
                e = tbl_rdata;
                e.feedback = e.base;
                e.slice    = grant_tab[e.base];
                tbl_we    = 1'b1;
                tbl_waddr = sel_reg;
                tbl_wdata = e;
                mode_next[sel_reg] = mfts_pkg::MODE_READY;
                q = {1'b0, e.base};
                fifo_we    = 1'b1;
                fifo_wdata = sel_reg;
                fifo_waddr = {q, head_reg[q] + count_next[q][TW-1:0]};
                count_next[q] = count_next[q] + 1'b1;
                left_next  = left_reg - 1'b1;
                state_next = S_RF_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[1:0] = status_reg;
                    if (cur_valid_reg)
                    begin
                        out_data_next[2]     = 1'b1;
                        out_data_next[6:3]   = cur_id_reg;
                        out_data_next[8:7]   = shadow_reg.base;
                        out_data_next[10:9]  = shadow_reg.feedback;
                        out_data_next[42:11] = shadow_reg.dispatches;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slice_top_reg <= 8'd8;
            slice_mid_reg <= 8'd4;
            slice_low_reg <= 8'd2;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            refill_reg    <= 1'b0;
            for (int i = 0; i < mfts_pkg::MAX_TASKS; i++)
            begin
                used_reg[i] <= 1'b0;
                mode_reg[i] <= mfts_pkg::MODE_READY;
            end
            for (int k = 0; k < mfts_pkg::QNUM; k++)
            begin
                head_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            refill_reg    <= refill_next;
            used_reg      <= used_next;
            mode_reg      <= mode_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mfts_pkg::CFG_TOP: slice_top_reg <= cfg_data;
                    mfts_pkg::CFG_MID: slice_mid_reg <= cfg_data;
                    mfts_pkg::CFG_LOW: slice_low_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        lvl_in_reg   <= lvl_in_next;
        now_reg      <= now_next;
        span_reg     <= span_next;
        shadow_reg   <= shadow_next;
        sel_reg      <= sel_next;
        lvl_reg      <= lvl_next;
        left_reg     <= left_next;
        status_reg   <= status_next;
    end

    // The queued task total never exceeds the task count
    a_queue_total: assert property (@(posedge clk) disable iff (!rst_n)
        ({3'd0, count_reg[0]} + {3'd0, count_reg[1]} + {3'd0, count_reg[2]}
         + {3'd0, count_reg[3]} + {3'd0, count_reg[4]}) <= 8'(mfts_pkg::MAX_TASKS))
        else $error("queued task total exceeds task count");

    // Between commands the running task is marked running
    a_run_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cur_valid_reg) |-> mode_reg[cur_id_reg] == mfts_pkg::MODE_RUN)
        else $error("running task not in run mode");

    // No memory writes while waiting for a command
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!tbl_we && !fifo_we))
        else $error("memory write while idle");
endmodule
`default_nettype wire
